// ===== design/bpo_pkg.sv =====
package bpo_pkg;

   localparam int OFFSET_W        = 40;
   localparam int VALUE_W         = 8;
   localparam int STATUS_W        = 2;
   localparam int SECTOR_COUNT_W  = 30;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 2;

   localparam int TABLE_DEPTH_DEF  = 256;
   localparam int SECTOR_BYTES_DEF = 2048;

   // Match reduction: 16 children per node, one register per level.
   localparam int RED_FANIN_LOG = 4;
   localparam int MATCH_W       = VALUE_W + 1;

   localparam logic [CSR_ADDR_W-1:0] CSR_SECTOR_COUNT_ADDR = 2'd0;

   localparam logic [STATUS_W-1:0] ST_ADDED    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REPLACED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic                mode;
      logic [OFFSET_W-1:0] byte_offset;
      logic [VALUE_W-1:0]  byte_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  data_out;
      logic                was_patched;
      logic [STATUS_W-1:0] load_status;
   } rsp_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic                insert;
      logic                replace;
      logic [OFFSET_W-1:0] key;
      logic [VALUE_W-1:0]  value;
   } cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_RED,
      S_COMMIT
   } state_type;

   function automatic int red_count(int n, int lvl);
      return (n + (1 << (RED_FANIN_LOG * lvl)) - 1) >> (RED_FANIN_LOG * lvl);
   endfunction

   function automatic int red_levels(int n);
      int lvl;
      lvl = 1;
      for (int i = 0; i < 8; i++) begin
         if ((1 << (RED_FANIN_LOG * lvl)) < n) begin
            lvl = lvl + 1;
         end
      end
      return lvl;
   endfunction

   // Position of the first node of a level in the flat node store.
   function automatic int red_base(int n, int lvl);
      int sum;
      sum = 0;
      for (int m = 1; m < lvl; m++) begin
         sum = sum + red_count(n, m);
      end
      return sum;
   endfunction

endpackage

// ===== design/bpo_cell.sv =====
module bpo_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 9
) (
   input  logic                           clock,
   input  bpo_pkg::cmd_type               cmd,
   input  logic [CNT_W-1:0]               count,
   input  logic [bpo_pkg::OFFSET_W-1:0]   left_offset,
   input  logic [bpo_pkg::VALUE_W-1:0]    left_val,
   input  logic                           left_gt,
   output logic [bpo_pkg::OFFSET_W-1:0]   entry_offset,
   output logic [bpo_pkg::VALUE_W-1:0]    entry_value,
   output logic                           gt,
   output logic [bpo_pkg::MATCH_W-1:0]    match
);

   logic [bpo_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [bpo_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic                         gt_ff, gt_in;
   logic                         eq_ff, eq_in;
   logic                         occupied;

   // An entry past the fill count acts as an offset above every key.
   always_comb begin
      occupied = CNT_W'(INDEX) < count;
      gt_in    = !occupied || (offset_ff > cmd.key);
      eq_in    = occupied && (offset_ff == cmd.key);
   end

   // Shift right from the insertion point on; the first greater cell takes the key.
   always_comb begin
      offset_in = offset_ff;
      value_in  = value_ff;
      if (cmd.replace && eq_ff) begin
         value_in = cmd.value;
      end else if (cmd.insert && gt_ff) begin
         if (left_gt) begin
            offset_in = left_offset;
            value_in  = left_val;
         end else begin
            offset_in = cmd.key;
            value_in  = cmd.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      value_ff  <= value_in;
      gt_ff     <= gt_in;
      eq_ff     <= eq_in;
   end

   assign entry_offset = offset_ff;
   assign entry_value  = value_ff;
   assign gt           = gt_ff;
   assign match        = {eq_ff, value_ff & {bpo_pkg::VALUE_W{eq_ff}}};

endmodule

// ===== design/bpo_reduce.sv =====
module bpo_reduce #(
   parameter int N = bpo_pkg::TABLE_DEPTH_DEF,
   parameter int W = bpo_pkg::MATCH_W
) (
   input  logic                clock,
   input  logic [N-1:0][W-1:0] leaves,
   output logic [W-1:0]        root
);

   localparam int LEVELS = bpo_pkg::red_levels(N);
   localparam int TOTAL  = bpo_pkg::red_base(N, LEVELS + 1);
   localparam int FANIN  = 1 << bpo_pkg::RED_FANIN_LOG;

   logic [W-1:0] node_ff [TOTAL];

   for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
      localparam int CNT  = bpo_pkg::red_count(N, l);
      localparam int PREV = bpo_pkg::red_count(N, l - 1);
      localparam int BASE = bpo_pkg::red_base(N, l);
      localparam int PBASE = bpo_pkg::red_base(N, l - 1);
      for (genvar g = 0; g < CNT; g++) begin : g_node
         localparam int FIRST = g * FANIN;
         localparam int KIDS  = (PREV - FIRST < FANIN) ? (PREV - FIRST) : FANIN;
         logic [W-1:0] node_in;
         if (l == 1) begin : g_leaf
            always_comb begin
               node_in = '0;
               for (int c = 0; c < KIDS; c++) begin
                  node_in = node_in | leaves[FIRST + c];
               end
            end
         end else begin : g_inner
            always_comb begin
               node_in = '0;
               for (int c = 0; c < KIDS; c++) begin
                  node_in = node_in | node_ff[PBASE + FIRST + c];
               end
            end
         end
         always_ff @(posedge clock) begin
            node_ff[BASE + g] <= node_in;
         end
      end
   end

   assign root = node_ff[TOTAL - 1];

endmodule

// ===== design/byte_patch_overlay_top.sv =====
// A beat accepted in idle passes through the compare state, the reduction wait and the
// commit state, which waits for a free output stage; the result is then registered.
// A new beat is taken only after the last one has committed; the pace is set by the
// registered 16-way match reduction over the cell chain, RED_LEVELS = ceil(log16 depth).
// Reset clears the fill count, the sector count and the handshake state; patch storage
// is not cleared, since only cells below the fill count take part in a match.
module byte_patch_overlay_top #(
   parameter int TABLE_DEPTH  = bpo_pkg::TABLE_DEPTH_DEF,
   parameter int SECTOR_BYTES = bpo_pkg::SECTOR_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // item channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bpo_pkg::req_type                 req_data,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bpo_pkg::rsp_type                 rsp_data,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bpo_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bpo_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bpo_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
   localparam int SB_W       = $clog2(SECTOR_BYTES + 1);
   localparam int LIM_W      = bpo_pkg::SECTOR_COUNT_W + SB_W;
   localparam int CMP_W      = (LIM_W > bpo_pkg::OFFSET_W) ? LIM_W : bpo_pkg::OFFSET_W;
   localparam int RED_LEVELS = bpo_pkg::red_levels(TABLE_DEPTH);
   localparam int RC_W       = $clog2(RED_LEVELS + 1);

   // ------------------------------------------------------------------
   // Register port. The sector count is kept for readback; the byte limit
   // (sector count * SECTOR_BYTES) is formed once, at the write.
   // ------------------------------------------------------------------
   logic [bpo_pkg::SECTOR_COUNT_W-1:0] sectors_ff;
   logic [LIM_W-1:0]                   limit_ff;
   logic                               csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == bpo_pkg::CSR_SECTOR_COUNT_ADDR);

   always_ff @(posedge clock) begin
      if (reset) begin
         sectors_ff <= '0;
         limit_ff   <= '0;
      end else if (csr_write) begin
         sectors_ff <= csr_pwdata[bpo_pkg::SECTOR_COUNT_W-1:0];
         limit_ff   <= LIM_W'(csr_pwdata[bpo_pkg::SECTOR_COUNT_W-1:0])
                       * LIM_W'(SECTOR_BYTES);
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == bpo_pkg::CSR_SECTOR_COUNT_ADDR) begin
         csr_prdata = bpo_pkg::CSR_DATA_W'(sectors_ff);
      end
   end

   // ------------------------------------------------------------------
   // Controller state
   // ------------------------------------------------------------------
   bpo_pkg::state_type state_ff, state_in;
   logic [RC_W-1:0]    red_cnt_ff, red_cnt_in;
   bpo_pkg::req_type   op_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bpo_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               commit_go;
   logic               in_range;
   logic               full;
   logic               match_any;
   logic [bpo_pkg::VALUE_W-1:0] match_value;
   logic [bpo_pkg::STATUS_W-1:0] status;
   bpo_pkg::cmd_type   cmd;

   // ------------------------------------------------------------------
   // Cell chain: each cell holds one sorted entry and hands it to its
   // right neighbor when a new patch is inserted ahead of it.
   // ------------------------------------------------------------------
   logic [bpo_pkg::OFFSET_W-1:0]                  cell_offset [TABLE_DEPTH];
   logic [bpo_pkg::VALUE_W-1:0]                   cell_value  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]                        cell_gt;
   logic [TABLE_DEPTH-1:0]                        cell_eq;
   logic [TABLE_DEPTH-1:0][bpo_pkg::MATCH_W-1:0]  cell_match;
   logic [bpo_pkg::MATCH_W-1:0]                   red_root;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         bpo_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock        (clock),
            .cmd          (cmd),
            .count        (count_ff),
            .left_offset  ('0),
            .left_val     ('0),
            .left_gt      (1'b0),
            .entry_offset (cell_offset[i]),
            .entry_value  (cell_value[i]),
            .gt           (cell_gt[i]),
            .match        (cell_match[i])
         );
      end else begin : g_body
         bpo_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock        (clock),
            .cmd          (cmd),
            .count        (count_ff),
            .left_offset  (cell_offset[i-1]),
            .left_val     (cell_value[i-1]),
            .left_gt      (cell_gt[i-1]),
            .entry_offset (cell_offset[i]),
            .entry_value  (cell_value[i]),
            .gt           (cell_gt[i]),
            .match        (cell_match[i])
         );
      end
      assign cell_eq[i] = cell_match[i][bpo_pkg::VALUE_W];
   end

   // At most one cell matches, so an OR tree yields both the hit and its value.
   bpo_reduce #(
      .N (TABLE_DEPTH),
      .W (bpo_pkg::MATCH_W)
   ) u_reduce (
      .clock  (clock),
      .leaves (cell_match),
      .root   (red_root)
   );

   assign match_any   = red_root[bpo_pkg::VALUE_W];
   assign match_value = red_root[bpo_pkg::VALUE_W-1:0];

   // ------------------------------------------------------------------
   // Decision at commit: bound first, then an existing offset, then full.
   // ------------------------------------------------------------------
   always_comb begin
      in_range = CMP_W'(op_ff.byte_offset) < CMP_W'(limit_ff);
      full     = count_ff == CNT_W'(TABLE_DEPTH);
      if (!in_range) begin
         status = bpo_pkg::ST_OUTSIDE;
      end else if (match_any) begin
         status = bpo_pkg::ST_REPLACED;
      end else if (full) begin
         status = bpo_pkg::ST_FULL;
      end else begin
         status = bpo_pkg::ST_ADDED;
      end
   end

   always_comb begin
      cmd.key     = op_ff.byte_offset;
      cmd.value   = op_ff.byte_value;
      cmd.replace = commit_go && !op_ff.mode && (status == bpo_pkg::ST_REPLACED);
      cmd.insert  = commit_go && !op_ff.mode && (status == bpo_pkg::ST_ADDED);
   end

   always_comb begin
      rsp_data_in = '0;
      if (op_ff.mode) begin
         rsp_data_in.was_patched = match_any;
         rsp_data_in.data_out    = match_any ? match_value : op_ff.byte_value;
      end else begin
         rsp_data_in.load_status = status;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer: latch the beat, let the cells compare, wait out the
   // reduction tree, then commit and hand the result to the output stage.
   // ------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      red_cnt_in = red_cnt_ff;
      req_ready  = 1'b0;
      commit_go  = 1'b0;
      unique case (state_ff)
         bpo_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = bpo_pkg::S_CMP;
            end
         end
         bpo_pkg::S_CMP: begin
            red_cnt_in = '0;
            state_in   = bpo_pkg::S_RED;
         end
         bpo_pkg::S_RED: begin
            red_cnt_in = red_cnt_ff + 1'b1;
            if (red_cnt_ff == RC_W'(RED_LEVELS - 1)) begin
               state_in = bpo_pkg::S_COMMIT;
            end
         end
         bpo_pkg::S_COMMIT: begin
            // hold until the output stage is free
            commit_go = !rsp_valid_ff || rsp_ready;
            if (commit_go) begin
               state_in = bpo_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bpo_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (commit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpo_pkg::S_IDLE;
         red_cnt_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         red_cnt_ff   <= red_cnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff <= req_data;
      end
      if (commit_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   a_unique_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpo_pkg::S_COMMIT) |-> $onehot0(cell_eq))
      else $error("more than one cell matches the key");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not advance the fill count");

   a_outside_keeps: assert property (@(posedge clock) disable iff (reset)
      (commit_go && !op_ff.mode && !in_range) |=> $stable(count_ff))
      else $error("rejected patch changed the table");

endmodule
